// ----- hdl/mhpq_pkg.sv -----
// Shared types and constants for the max-heap priority queue
package mhpq_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] priority_req;
    logic [15:0] tag;
  } req_t;

  typedef struct packed {
    logic [15:0] out_priority;
    logic [15:0] out_tag;
    logic        has_entry;
    logic        error;
    logic [7:0]  count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] prio;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT_RD,
    S_ROOT_CAP,
    S_LAST_CAP,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_src_e;

  typedef enum logic [1:0] {
    WR_ITEM,
    WR_RDATA,
    WR_BEST
  } wr_src_e;

  typedef enum logic [1:0] {
    POS_ZERO,
    POS_PARENT,
    POS_BEST
  } pos_src_e;

  typedef struct packed {
    logic     accept;
    logic     err_set;
    logic     rd_en;
    rd_src_e  rd_src;
    logic     wr_en;
    wr_src_e  wr_src;
    logic     pos_ld;
    pos_src_e pos_src;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cap_root;
    logic     cap_last;
    logic     cap_left;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic is_push;
    logic is_peek;
    logic pos_zero;
    logic up_move;
    logic left_out;
    logic best_child;
    logic slot_free;
  } status_t;

endpackage

// ----- hdl/max_heap_priority_queue.sv -----
// Top level of the binary max-heap priority queue
// Peek reads the root entry; push lets the new entry rise past each lower-priority parent.
// Pop reads the root, moves the last entry to the root and lets it sink while a child is higher.
// The heap RAM has a single read port; one item is in work at a time.
// Reset clears the entry count and the handshake state; the heap RAM is not cleared.
module max_heap_priority_queue #(
  parameter int unsigned DEPTH = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mhpq_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mhpq_pkg::rsp_t out_data_o
);
  import mhpq_pkg::*;

  cmd_t    cmd;
  status_t status;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mhpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/mhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module mhpq_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mhpq_ctrl.sv -----
// Sequencer for push, pop and peek over the heap datapath
module mhpq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mhpq_pkg::status_t status_i,
  output mhpq_pkg::cmd_t    cmd_o
);
  import mhpq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (status_i.reject)       state_d = S_DONE;
        else if (status_i.is_push) state_d = S_UP_RD;
        else                       state_d = S_ROOT_RD;
      end
      S_UP_RD: begin
        state_d = status_i.pos_zero ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_d = status_i.up_move ? S_UP_RD : S_DONE;
      end
      S_ROOT_RD:  state_d = S_ROOT_CAP;
      S_ROOT_CAP: state_d = status_i.is_peek ? S_DONE : S_LAST_CAP;
      S_LAST_CAP: state_d = S_DN_L;
      S_DN_L: begin
        state_d = status_i.left_out ? S_DONE : S_DN_R;
      end
      S_DN_R:     state_d = S_DN_CMP;
      S_DN_CMP: begin
        state_d = status_i.best_child ? S_DN_L : S_DONE;
      end
      S_DONE: begin
        if (status_i.slot_free) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.err_set = status_i.reject;
      end
      S_UP_RD: begin
        if (status_i.pos_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_src  = WR_ITEM;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.up_move) begin
          cmd_o.wr_src  = WR_RDATA;
          cmd_o.pos_ld  = 1'b1;
          cmd_o.pos_src = POS_PARENT;
        end else begin
          cmd_o.wr_src  = WR_ITEM;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_ROOT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_ROOT;
      end
      S_ROOT_CAP: begin
        cmd_o.cap_root = 1'b1;
        if (!status_i.is_peek) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_src  = RD_LAST;
          cmd_o.cnt_dec = 1'b1;
        end
      end
      S_LAST_CAP: begin
        cmd_o.cap_last = 1'b1;
        cmd_o.pos_ld   = 1'b1;
        cmd_o.pos_src  = POS_ZERO;
      end
      S_DN_L: begin
        if (status_i.left_out) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = WR_ITEM;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_LEFT;
        end
      end
      S_DN_R: begin
        cmd_o.cap_left = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_src   = RD_RIGHT;
      end
      S_DN_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.best_child) begin
          cmd_o.wr_src  = WR_BEST;
          cmd_o.pos_ld  = 1'b1;
          cmd_o.pos_src = POS_BEST;
        end else begin
          cmd_o.wr_src = WR_ITEM;
        end
      end
      S_DONE: begin
        cmd_o.out_load = status_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- hdl/mhpq_datapath.sv -----
// Heap storage, index arithmetic, compare logic and result register
module mhpq_datapath #(
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhpq_pkg::req_t    in_data_i,
  input  mhpq_pkg::cmd_t    cmd_i,
  output mhpq_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mhpq_pkg::rsp_t    out_data_o
);
  import mhpq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = AW + 2;

  logic [1:0]    op_q;
  entry_t        item_q;
  logic [AW-1:0] pos_q;
  logic [CW-1:0] count_q;
  entry_t        cand_q;
  logic          cand_child_q;
  logic [AW-1:0] cand_idx_q;
  rsp_t          res_q;
  rsp_t          out_q;
  logic          out_valid_q;

  entry_t        rdata;
  entry_t        wdata;
  entry_t        best;
  logic [AW-1:0] raddr;
  logic [AW-1:0] parent;
  logic [AW-1:0] best_idx;
  logic [IW-1:0] left_w;
  logic [IW-1:0] right_w;
  logic [IW-1:0] count_w;
  logic          right_win;
  logic          slot_free;

  assign parent    = AW'((pos_q - 1'b1) >> 1);
  assign left_w    = IW'({pos_q, 1'b1});
  assign right_w   = left_w + 1'b1;
  assign count_w   = IW'(count_q);
  assign right_win = (right_w < count_w) && (rdata.prio > cand_q.prio);
  assign best      = right_win ? rdata : cand_q;
  assign best_idx  = right_win ? right_w[AW-1:0] : cand_idx_q;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.rd_src)
      RD_ROOT:   raddr = '0;
      RD_PARENT: raddr = parent;
      RD_LAST:   raddr = AW'(count_q - 1'b1);
      RD_LEFT:   raddr = left_w[AW-1:0];
      RD_RIGHT:  raddr = right_w[AW-1:0];
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_src)
      WR_ITEM:  wdata = item_q;
      WR_RDATA: wdata = rdata;
      WR_BEST:  wdata = best;
      default:  wdata = item_q;
    endcase
  end

  mhpq_ram #(
    .DW    (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    status_o         = '0;
    status_o.is_push = (op_q == OP_PUSH);
    status_o.is_peek = (op_q == OP_PEEK);
    if (op_q == OP_PUSH) begin
      status_o.reject = (count_q == CW'(DEPTH));
    end else if ((op_q == OP_POP) || (op_q == OP_PEEK)) begin
      status_o.reject = (count_q == '0);
    end else begin
      status_o.reject = 1'b1;
    end
    status_o.pos_zero   = (pos_q == '0);
    status_o.up_move    = (rdata.prio < item_q.prio);
    status_o.left_out   = (left_w >= count_w);
    status_o.best_child = right_win || cand_child_q;
    status_o.slot_free  = slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_data_i.op;
      item_q <= {in_data_i.priority_req, in_data_i.tag};
      pos_q  <= count_q[AW-1:0];
      res_q  <= '0;
    end else begin
      if (cmd_i.pos_ld) begin
        case (cmd_i.pos_src)
          POS_ZERO:   pos_q <= '0;
          POS_PARENT: pos_q <= parent;
          POS_BEST:   pos_q <= best_idx;
          default:    pos_q <= '0;
        endcase
      end
      if (cmd_i.cap_last) begin
        item_q <= rdata;
      end
      if (cmd_i.err_set) begin
        res_q.error <= 1'b1;
      end
      if (cmd_i.cap_root) begin
        res_q.out_priority <= rdata.prio;
        res_q.out_tag      <= rdata.tag;
        res_q.has_entry    <= 1'b1;
      end
    end
    if (cmd_i.cap_left) begin
      cand_child_q <= (rdata.prio > item_q.prio);
      cand_q       <= (rdata.prio > item_q.prio) ? rdata : item_q;
      cand_idx_q   <= left_w[AW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q <= '{out_priority: res_q.out_priority,
                 out_tag:      res_q.out_tag,
                 has_entry:    res_q.has_entry,
                 error:        res_q.error,
                 count:        8'(count_q)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/tb_max_heap_priority_queue.sv -----
// Self-checking testbench for the max-heap priority queue: random push/pop/peek traffic
module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int unsigned HEAP_DEPTH   = 128;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          TARGET_ITEMS = 1300;
  localparam int          TAIL_ITEMS   = 100;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          QUIET_LIMIT  = 4000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  req_t in_data_i   = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_data_o;

  req_t   pending_req[$];
  rsp_t   expected_rsp[$];
  entry_t heap_model[HEAP_DEPTH];
  int unsigned heap_fill = 0;
  int unsigned gen_fill  = 0;
  int     mismatch_count = 0;
  int     result_index   = 0;
  int     quiet_cycles   = 0;
  int     in_gap  = 0;
  int     out_gap = 0;

  max_heap_priority_queue #(
    .DEPTH(HEAP_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic rsp_t predict_response(req_t r);
    rsp_t        rsp;
    entry_t      tmp;
    int unsigned pos;
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    bit          moving;
    rsp = '0;
    case (r.op)
      OP_PUSH: begin
        if (heap_fill >= HEAP_DEPTH) begin
          rsp.error = 1'b1;
        end else begin
          heap_model[heap_fill] = '{prio: r.priority_req, tag: r.tag};
          pos = heap_fill;
          while (pos > 0 && heap_model[(pos - 1) / 2].prio < heap_model[pos].prio) begin
            tmp = heap_model[(pos - 1) / 2];
            heap_model[(pos - 1) / 2] = heap_model[pos];
            heap_model[pos] = tmp;
            pos = (pos - 1) / 2;
          end
          heap_fill++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (heap_fill == 0) begin
          rsp.error = 1'b1;
        end else begin
          rsp.out_priority = heap_model[0].prio;
          rsp.out_tag      = heap_model[0].tag;
          rsp.has_entry    = 1'b1;
          if (r.op == OP_POP) begin
            heap_model[0] = heap_model[heap_fill - 1];
            heap_fill--;
            pos = 0;
            moving = 1'b1;
            while (moving) begin
              lc = 2 * pos + 1;
              rc = 2 * pos + 2;
              best = pos;
              if (lc < heap_fill && heap_model[lc].prio > heap_model[best].prio) best = lc;
              if (rc < heap_fill && heap_model[rc].prio > heap_model[best].prio) best = rc;
              if (best == pos) begin
                moving = 1'b0;
              end else begin
                tmp = heap_model[pos];
                heap_model[pos] = heap_model[best];
                heap_model[best] = tmp;
                pos = best;
              end
            end
          end
        end
      end
      default: begin
        rsp.error = 1'b1;
      end
    endcase
    rsp.count = heap_fill[7:0];
    return rsp;
  endfunction

  function automatic void add_item(logic [1:0] op, logic [15:0] prio, logic [15:0] tag);
    req_t r;
    r.op           = op;
    r.priority_req = prio;
    r.tag          = tag;
    pending_req.push_back(r);
    if (op == OP_PUSH && gen_fill < HEAP_DEPTH) gen_fill++;
    if (op == OP_POP && gen_fill > 0) gen_fill--;
  endfunction

  function automatic logic [15:0] rand_priority();
    logic [15:0] p;
    case ($urandom_range(0, 3))
      0: p = 16'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: p = 16'h0000;
          1: p = 16'hFFFF;
          2: p = 16'h7FFF;
          default: p = 16'h8000;
        endcase
      end
      default: p = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return p;
  endfunction

  function automatic logic [15:0] rand_tag();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic int idle_percent();
    if (pending_req.size() <= TAIL_ITEMS) return 0;
    case ((pending_req.size() / 97) % 3)
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got 0x%0h, want 0x%0h", result_index, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsp.push_back(predict_response(in_data_i));
        void'(pending_req.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_req.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_percent()) begin
          in_gap     <= $urandom_range(0, 15);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_req[0];
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("out_valid_o", 32'd1, 32'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_data_o.out_priority !== want.out_priority)
            report_mismatch("out_priority", 32'(out_data_o.out_priority),
                            32'(want.out_priority));
          if (out_data_o.out_tag !== want.out_tag)
            report_mismatch("out_tag", 32'(out_data_o.out_tag), 32'(want.out_tag));
          if (out_data_o.has_entry !== want.has_entry)
            report_mismatch("has_entry", 32'(out_data_o.has_entry), 32'(want.has_entry));
          if (out_data_o.error !== want.error)
            report_mismatch("error", 32'(out_data_o.error), 32'(want.error));
          if (out_data_o.count !== want.count)
            report_mismatch("count", 32'(out_data_o.count), 32'(want.count));
        end
        result_index <= result_index + 1;
      end
      if (out_gap > 0) begin
        out_gap     <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_percent()) begin
        out_gap     <= $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("max_heap_priority_queue test failed");
    $finish;
  end

  initial begin
    int phase;
    int extra;
    int pick;
    int span;

    // empty-heap rejections and the unused selector
    add_item(OP_PEEK, 16'h0000, 16'h0000);
    add_item(OP_POP, 16'hFFFF, 16'hFFFF);
    add_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    // extremes and equal priorities
    add_item(OP_PUSH, 16'hFFFF, 16'h0000);
    add_item(OP_PUSH, 16'h0000, 16'hFFFF);
    add_item(OP_PUSH, 16'h8000, 16'h1234);
    add_item(OP_PUSH, 16'h7FFF, 16'hEDCB);
    add_item(OP_PUSH, 16'h8000, 16'hAAAA);
    add_item(OP_PUSH, 16'h8000, 16'h5555);
    add_item(OP_PEEK, 16'h0000, 16'h0000);
    add_item(OP_UNUSED, 16'h0000, 16'h0000);
    repeat (6) add_item(OP_POP, 16'h0000, 16'h0000);
    add_item(OP_POP, 16'h0000, 16'h0000);
    add_item(OP_PEEK, 16'hFFFF, 16'hFFFF);

    while (pending_req.size() < TARGET_ITEMS) begin
      phase = $urandom_range(0, 3);
      if (phase == 0) begin
        while (gen_fill < HEAP_DEPTH) begin
          if ($urandom_range(0, 9) == 0) add_item(OP_PEEK, rand_priority(), rand_tag());
          else add_item(OP_PUSH, rand_priority(), rand_tag());
        end
        extra = $urandom_range(1, 3);
        repeat (extra) add_item(OP_PUSH, rand_priority(), rand_tag());
      end else if (phase == 1) begin
        while (gen_fill > 0) begin
          if ($urandom_range(0, 9) == 0) add_item(OP_PEEK, rand_priority(), rand_tag());
          else add_item(OP_POP, rand_priority(), rand_tag());
        end
        extra = $urandom_range(1, 2);
        repeat (extra) begin
          if ($urandom_range(0, 1) == 0) add_item(OP_POP, rand_priority(), rand_tag());
          else add_item(OP_PEEK, rand_priority(), rand_tag());
        end
      end else begin
        span = $urandom_range(20, 80);
        repeat (span) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) add_item(OP_PUSH, rand_priority(), rand_tag());
          else if (pick < 85) add_item(OP_POP, rand_priority(), rand_tag());
          else if (pick < 97) add_item(OP_PEEK, rand_priority(), rand_tag());
          else add_item(OP_UNUSED, rand_priority(), rand_tag());
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_req.size() != 0 || in_valid_i || expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("max_heap_priority_queue test passed");
    end else begin
      $display("max_heap_priority_queue test failed");
    end
    $finish;
  end

endmodule
